FILE: rtl/llst_pkg.sv
// Shared types and constants for the least-loaded server table.
// Used by llst_front, llst_back and least_loaded_server_table_core.
`timescale 1ns / 1ps
`default_nettype none

package llst_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int ID_W     = 16;
    localparam int PORT_W   = 16;
    localparam int LOAD_W   = 20;
    localparam int TOTAL_W  = 24;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 80;

    localparam int QPTR_W = 2;
    localparam int QDEPTH = 2 ** QPTR_W;

    localparam logic [CMD_W-1:0] CMD_REGISTER  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INCREMENT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DECREMENT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SELECT    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ALLFULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TABLEFULL = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd5;

    localparam logic [LOAD_W-1:0]  LOAD_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_REG,
        OP_INC,
        OP_DEC,
        OP_REM,
        OP_SEL
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [LOAD_W-1:0] iload;
        logic [LOAD_W-1:0] limit;
    } cmd_t;

    typedef struct packed {
        logic [LOAD_W-1:0] limit;
        logic [LOAD_W-1:0] load;
        logic [PORT_W-1:0] port;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     chosen_id;
        logic [PORT_W-1:0]   chosen_port;
        logic [LOAD_W-1:0]   chosen_load;
        logic [TOTAL_W-1:0]  total_load;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/llst_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module llst_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/llst_front.sv
// Input side: takes command words, decodes the command code and queues them.
// Depends on llst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module llst_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // id[15:0], port[31:16], initial_load[51:32], load_limit[71:52]
    input  wire logic [llst_pkg::S_DATA_W-1:0] s_axis_tdata,
    // cmd[2:0]
    input  wire logic [llst_pkg::CMD_W-1:0]    s_axis_tuser,
    output logic                               q_valid,
    output llst_pkg::cmd_t                     q_word,
    input  wire logic                          q_pop
);

    import llst_pkg::*;

    cmd_t              queue_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;
    cmd_t              in_word;

    always_comb
    begin
        in_word.id    = s_axis_tdata[15:0];
        in_word.port  = s_axis_tdata[31:16];
        in_word.iload = s_axis_tdata[51:32];
        in_word.limit = s_axis_tdata[71:52];
        case (s_axis_tuser)
            CMD_REGISTER:  in_word.op = OP_REG;
            CMD_INCREMENT: in_word.op = OP_INC;
            CMD_DECREMENT: in_word.op = OP_DEC;
            CMD_REMOVE:    in_word.op = OP_REM;
            CMD_SELECT:    in_word.op = OP_SEL;
            default:       in_word.op = OP_NOP;
        endcase
    end

    assign s_axis_tready = (count_reg != (QPTR_W + 1)'(QDEPTH));
    assign q_valid       = (count_reg != '0);
    assign q_word        = queue_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/llst_back.sv
// Command engine: scans the server table one slot a cycle, then applies the
// command and loads the result register. Depends on llst_pkg, llst_ram.
`timescale 1ns / 1ps
`default_nettype none

module llst_back #(
    parameter int SERVERS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_valid,
    input  wire llst_pkg::cmd_t q_word,
    output logic           q_pop,
    output logic           m_valid,
    input  wire logic      m_ready,
    output llst_pkg::result_t m_word
);

    import llst_pkg::*;

    localparam int IDX_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SERVERS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    cmd_t               cur_reg;
    logic [IDX_W-1:0]   addr_reg;
    logic [IDX_W-1:0]   addr_next;
    logic               p_vld_reg;
    logic [IDX_W-1:0]   p_slot_reg;
    logic               p_ev_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_slot_reg;
    entry_t             hit_entry_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_slot_reg;
    logic               any_reg;
    logic               best_reg;
    entry_t             best_entry_reg;
    logic [SERVERS-1:0] valid_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic               m_valid_reg;
    result_t            out_reg;
    result_t            res_next;

    entry_t             rd_entry;
    logic [$bits(entry_t)-1:0] ram_rdata;
    logic               ram_we;
    logic               we_op;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;

    logic               out_free;
    logic               exec_go;
    logic               start;
    logic               set_valid;
    logic               clr_valid;
    logic               is_better;
    logic [LOAD_W-1:0]  amount;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] add_sat;
    logic [TOTAL_W-1:0] sub_sat;

    llst_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SERVERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry = ram_rdata;
    assign out_free = !m_valid_reg || m_ready;
    assign exec_go  = (state_reg == S_EXEC) && out_free;
    assign start    = (state_reg == S_IDLE) && q_valid;
    assign q_pop    = start;
    assign ram_we   = exec_go && we_op;
    assign m_valid  = m_valid_reg;
    assign m_word   = out_reg;

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_SCAN;
                    addr_next  = '0;
                end
            end
            S_SCAN:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // lower load wins, equal load goes to the lower id
    assign is_better = p_ev_reg && (rd_entry.load < rd_entry.limit) &&
                       (!best_reg || (rd_entry.load < best_entry_reg.load) ||
                        ((rd_entry.load == best_entry_reg.load) &&
                         (rd_entry.id < best_entry_reg.id)));

    always_comb
    begin
        case (cur_reg.op)
            OP_REG:  amount = cur_reg.iload;
            OP_REM:  amount = hit_entry_reg.load;
            default: amount = LOAD_W'(1);
        endcase
    end

    assign sum     = {1'b0, total_reg} + (TOTAL_W + 1)'(amount);
    assign add_sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    assign sub_sat = (TOTAL_W'(amount) > total_reg) ? '0 : total_reg - TOTAL_W'(amount);

    always_comb
    begin
        res_next   = '0;
        total_next = total_reg;
        we_op      = 1'b0;
        ram_waddr  = hit_slot_reg;
        ram_wdata  = hit_entry_reg;
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        res_next.status = ST_OK;
        case (cur_reg.op)
            OP_REG:
            begin
                if (hit_reg)
                begin
                    res_next.status = ST_DUP;
                end
                else if (!free_reg)
                begin
                    res_next.status = ST_TABLEFULL;
                end
                else
                begin
                    we_op           = 1'b1;
                    ram_waddr       = free_slot_reg;
                    ram_wdata.id    = cur_reg.id;
                    ram_wdata.port  = cur_reg.port;
                    ram_wdata.load  = cur_reg.iload;
                    ram_wdata.limit = cur_reg.limit;
                    set_valid       = 1'b1;
                    total_next      = add_sat;
                end
            end
            OP_INC:
            begin
                if (!hit_reg)
                begin
                    res_next.status = ST_NOTFOUND;
                end
                else if (hit_entry_reg.load != LOAD_MAX)
                begin
                    we_op          = 1'b1;
                    ram_wdata.load = hit_entry_reg.load + 1'b1;
                    total_next     = add_sat;
                end
            end
            OP_DEC:
            begin
                if (!hit_reg)
                begin
                    res_next.status = ST_NOTFOUND;
                end
                else if (hit_entry_reg.load != '0)
                begin
                    we_op          = 1'b1;
                    ram_wdata.load = hit_entry_reg.load - 1'b1;
                    total_next     = sub_sat;
                end
            end
            OP_REM:
            begin
                if (!hit_reg)
                begin
                    res_next.status = ST_NOTFOUND;
                end
                else
                begin
                    clr_valid  = 1'b1;
                    total_next = sub_sat;
                end
            end
            OP_SEL:
            begin
                if (!any_reg)
                begin
                    res_next.status = ST_EMPTY;
                end
                else if (!best_reg)
                begin
                    res_next.status = ST_ALLFULL;
                end
                else
                begin
                    res_next.chosen_id   = best_entry_reg.id;
                    res_next.chosen_port = best_entry_reg.port;
                    res_next.chosen_load = best_entry_reg.load;
                end
            end
            default:
            begin
                res_next.status = ST_OK;
            end
        endcase
        res_next.total_load = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            addr_reg    <= '0;
            p_vld_reg   <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            any_reg     <= 1'b0;
            best_reg    <= 1'b0;
            valid_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            p_vld_reg <= (state_reg == S_SCAN);
            if (start)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
                any_reg  <= 1'b0;
                best_reg <= 1'b0;
            end
            else if (p_vld_reg)
            begin
                if (p_ev_reg && (rd_entry.id == cur_reg.id))
                begin
                    hit_reg <= 1'b1;
                end
                if (!p_ev_reg)
                begin
                    free_reg <= 1'b1;
                end
                if (p_ev_reg)
                begin
                    any_reg <= 1'b1;
                end
                if (is_better)
                begin
                    best_reg <= 1'b1;
                end
            end
            if (exec_go)
            begin
                total_reg <= total_next;
                if (set_valid)
                begin
                    valid_reg[free_slot_reg] <= 1'b1;
                end
                if (clr_valid)
                begin
                    valid_reg[hit_slot_reg] <= 1'b0;
                end
            end
            if (exec_go)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg <= q_word;
        end
        if (state_reg == S_SCAN)
        begin
            p_slot_reg <= addr_reg;
            p_ev_reg   <= valid_reg[addr_reg];
        end
        if (p_vld_reg && !start)
        begin
            if (p_ev_reg && (rd_entry.id == cur_reg.id) && !hit_reg)
            begin
                hit_slot_reg  <= p_slot_reg;
                hit_entry_reg <= rd_entry;
            end
            if (!p_ev_reg && !free_reg)
            begin
                free_slot_reg <= p_slot_reg;
            end
            if (is_better)
            begin
                best_entry_reg <= rd_entry;
            end
        end
        if (exec_go)
        begin
            out_reg <= res_next;
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid && (state_reg == S_IDLE))
        else $error("pop outside idle");

    a_we_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_EXEC))
        else $error("table write outside exec");

    a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> $stable(total_reg))
        else $error("total moved outside exec");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> m_valid_reg)
        else $error("result not presented");

    a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && (out_reg.status != ST_OK) |->
            (out_reg.chosen_id == '0) && (out_reg.chosen_load == '0))
        else $error("chosen fields set on failed command");

endmodule

`default_nettype wire

FILE: rtl/least_loaded_server_table_core.sv
// Least-loaded server table top level: packs the stream words, joins the
// input queue (llst_front) and the scan engine (llst_back). Depends on llst_pkg.
// The engine takes no new word from the input queue until the current one has
// gone through the one-slot-per-cycle table scan through the single table read
// port and its result is loaded into the result register; the queue holds 4 words.
// Reset: valid bits, running total, queue and result valid flag clear at once.
`timescale 1ns / 1ps
`default_nettype none

module least_loaded_server_table_core #(
    parameter int SERVERS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // server_id[15:0], server_port[31:16], initial_load[51:32], load_limit[71:52]
    input  wire logic [llst_pkg::S_DATA_W-1:0] s_axis_tdata,
    // cmd[2:0]
    input  wire logic [llst_pkg::CMD_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // chosen_id[15:0], chosen_port[31:16], chosen_load[51:32],
    // total_load[75:52], zero[79:76]
    output logic      [llst_pkg::M_DATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic      [llst_pkg::STATUS_W-1:0] m_axis_tuser
);

    import llst_pkg::*;

    logic    q_valid;
    cmd_t    q_word;
    logic    q_pop;
    result_t res;

    llst_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_word        (q_word),
        .q_pop         (q_pop)
    );

    llst_back #(
        .SERVERS (SERVERS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_word  (res)
    );

    assign m_axis_tdata = {4'b0000, res.total_load, res.chosen_load,
                           res.chosen_port, res.chosen_id};
    assign m_axis_tuser = res.status;

endmodule

`default_nettype wire
